// File: rtl/core/weekly_sleep_wake_scheduler_assert.svh
// Assertion macros used by the scheduler top module.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef WEEKLY_SLEEP_WAKE_SCHEDULER_ASSERT_SVH
`define WEEKLY_SLEEP_WAKE_SCHEDULER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define WSSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define WSSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/wssw_pkg.sv
package wssw_pkg;

    localparam int KEY_W  = 20;
    localparam int SECS_W = 17;
    localparam int MINS_W = 11;

    localparam logic [KEY_W-1:0]  KEY_NONE     = '1;
    localparam logic [KEY_W-1:0]  MIN_PER_DAY  = 20'd1440;
    localparam logic [MINS_W-1:0] MIN_PER_HOUR = 11'd60;
    localparam logic [SECS_W-1:0] SEC_PER_HOUR = 17'd3600;
    localparam logic [SECS_W-1:0] SEC_PER_MIN  = 17'd60;
    localparam logic [2:0]        CD_MAX       = 3'd5;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;

    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_INTERVAL = 2'd1;
    localparam logic [1:0] MODE_STOPPED  = 2'd2;

    localparam logic [1:0] CD_NONE  = 2'd0;
    localparam logic [1:0] CD_SLEEP = 2'd1;
    localparam logic [1:0] CD_WAKE  = 2'd2;

    localparam logic [4:0] SLEEP_HOUR_RST  = 5'd0;
    localparam logic [5:0] SLEEP_MIN_RST   = 6'd0;
    localparam logic [4:0] WAKE_HOUR_RST   = 5'd8;
    localparam logic [5:0] WAKE_MIN_RST    = 6'd0;

    typedef enum logic [2:0] {
        CFG_ENABLE       = 3'd0,
        CFG_DAY_MASK     = 3'd1,
        CFG_SLEEP_HOUR   = 3'd2,
        CFG_SLEEP_MINUTE = 3'd3,
        CFG_WAKE_HOUR    = 3'd4,
        CFG_WAKE_MINUTE  = 3'd5,
        CFG_RUN_MODE     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic       scheduler_enable;
        logic [6:0] day_mask;
        logic [4:0] sleep_hour;
        logic [5:0] sleep_minute;
        logic [4:0] wake_hour;
        logic [5:0] wake_minute;
        logic [1:0] run_mode;
    } t_cfg;

    typedef struct packed {
        logic       time_valid;
        logic [2:0] weekday;
        logic [8:0] year_day;
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
    } t_item;

    typedef struct packed {
        logic       sleep_event;
        logic       wake_event;
        logic [1:0] wake_mode;
        logic       sleeping_now;
        logic [1:0] countdown_kind;
        logic [2:0] countdown_left;
        logic       awake_window;
    } t_result;

    typedef struct packed {
        logic             sleeping;
        logic [KEY_W-1:0] last_sleep_key;
        logic [KEY_W-1:0] last_wake_key;
    } t_state;

endpackage

// File: rtl/core/weekly_sleep_wake_scheduler.sv
// Weekly sleep and wake scheduler, driven by one calendar tick per beat.
// Input channel (i_in_valid / o_in_ready) carries the calendar time of a tick;
// the output channel (o_out_valid / i_out_ready) returns one result beat per tick
// with the sleep and wake events, the sleeping flag, a one to five second
// countdown and the awake-window flag.
// The configuration channel (i_cfg_valid / o_cfg_ready) is always ready; a beat
// writes register i_cfg_index with i_cfg_data. Index 7 is ignored. Writing the
// enable register with zero also clears the sleeping flag. Write only while idle.
// A tick is accepted into the input register, evaluated there, and its result is
// registered in the output register, from which its result beat is taken.
// Throughput: one tick per cycle. The tick sits in an input register, the whole
// evaluation is one combinational pass, and the result lands in an output register.
// When the receiver stalls, the output register holds its beat, the input
// register still takes one more tick, and then o_in_ready drops until the
// output moves.
// Reset clears both pipeline stages, the sleeping flag and the remembered minute
// keys, and loads the register defaults (disabled, wake at 8:00, run mode off).
`include "weekly_sleep_wake_scheduler_assert.svh"

module weekly_sleep_wake_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_time_valid,
    input  logic [2:0] i_weekday,
    input  logic [8:0] i_year_day,
    input  logic [4:0] i_hour_now,
    input  logic [5:0] i_minute_now,
    input  logic [5:0] i_second_now,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_sleep_event,
    output logic       o_wake_event,
    output logic [1:0] o_wake_mode,
    output logic       o_sleeping_now,
    output logic [1:0] o_countdown_kind,
    output logic [2:0] o_countdown_left,
    output logic       o_awake_window,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    wssw_pkg::t_cfg    cfg;
    logic              clr_sleep;
    wssw_pkg::t_state  eval_state;
    wssw_pkg::t_result eval_result;

    logic              r_in_vld;
    logic              n_in_vld;
    wssw_pkg::t_item   r_item;
    logic              r_out_vld;
    logic              n_out_vld;
    wssw_pkg::t_result r_result;
    wssw_pkg::t_state  r_state;
    wssw_pkg::t_state  n_state;

    logic              in_acc;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    wssw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_clr_sleep (clr_sleep)
    );

    wssw_eval u_eval (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (eval_state),
        .o_result (eval_result)
    );

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (advance) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (advance) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end

        n_state = r_state;
        if (advance) begin
            n_state = eval_state;
        end
        if (clr_sleep) begin
            n_state.sleeping = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld               <= 1'b0;
            r_out_vld              <= 1'b0;
            r_state.sleeping       <= 1'b0;
            r_state.last_sleep_key <= wssw_pkg::KEY_NONE;
            r_state.last_wake_key  <= wssw_pkg::KEY_NONE;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            r_state   <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.time_valid <= i_time_valid;
            r_item.weekday    <= i_weekday;
            r_item.year_day   <= i_year_day;
            r_item.hour_now   <= i_hour_now;
            r_item.minute_now <= i_minute_now;
            r_item.second_now <= i_second_now;
        end
        if (advance) begin
            r_result <= eval_result;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_sleep_event    = r_result.sleep_event;
    assign o_wake_event     = r_result.wake_event;
    assign o_wake_mode      = r_result.wake_mode;
    assign o_sleeping_now   = r_result.sleeping_now;
    assign o_countdown_kind = r_result.countdown_kind;
    assign o_countdown_left = r_result.countdown_left;
    assign o_awake_window   = r_result.awake_window;

    `WSSW_ASSERT_NOW(a_sleep_sets_flag,
        o_out_valid && o_sleep_event && !o_wake_event, o_sleeping_now,
        "sleep event without sleeping flag")
    `WSSW_ASSERT_NOW(a_wake_clears_flag,
        o_out_valid && o_wake_event, !o_sleeping_now && (o_wake_mode != 2'd3),
        "wake event left sleeping flag set or bad mode")
    `WSSW_ASSERT_NOW(a_countdown_range,
        o_out_valid, (o_countdown_kind == wssw_pkg::CD_NONE) == (o_countdown_left == 3'd0)
        && (o_countdown_left <= wssw_pkg::CD_MAX),
        "countdown kind and seconds disagree")
    `WSSW_ASSERT_NEXT(a_disable_clears_sleep,
        i_cfg_valid && o_cfg_ready && (i_cfg_index == wssw_pkg::CFG_ENABLE)
        && !i_cfg_data[0], !r_state.sleeping,
        "disable write did not clear sleeping flag")

endmodule

// File: rtl/core/wssw_cfg.sv
module wssw_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [2:0]     i_cfg_index,
    input  logic [6:0]     i_cfg_data,
    output wssw_pkg::t_cfg o_cfg,
    output logic           o_clr_sleep
);

    wssw_pkg::t_cfg r_cfg;
    wssw_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg       = r_cfg;
        o_clr_sleep = 1'b0;
        if (i_cfg_valid) begin
            unique case (wssw_pkg::t_cfg_idx'(i_cfg_index))
                wssw_pkg::CFG_ENABLE: begin
                    n_cfg.scheduler_enable = i_cfg_data[0];
                    o_clr_sleep            = !i_cfg_data[0];
                end
                wssw_pkg::CFG_DAY_MASK: begin
                    n_cfg.day_mask = i_cfg_data;
                end
                wssw_pkg::CFG_SLEEP_HOUR: begin
                    n_cfg.sleep_hour = (i_cfg_data[4:0] > wssw_pkg::HOUR_MAX)
                        ? wssw_pkg::SLEEP_HOUR_RST : i_cfg_data[4:0];
                end
                wssw_pkg::CFG_SLEEP_MINUTE: begin
                    n_cfg.sleep_minute = (i_cfg_data[5:0] > wssw_pkg::MINUTE_MAX)
                        ? wssw_pkg::SLEEP_MIN_RST : i_cfg_data[5:0];
                end
                wssw_pkg::CFG_WAKE_HOUR: begin
                    n_cfg.wake_hour = (i_cfg_data[4:0] > wssw_pkg::HOUR_MAX)
                        ? wssw_pkg::WAKE_HOUR_RST : i_cfg_data[4:0];
                end
                wssw_pkg::CFG_WAKE_MINUTE: begin
                    n_cfg.wake_minute = (i_cfg_data[5:0] > wssw_pkg::MINUTE_MAX)
                        ? wssw_pkg::WAKE_MIN_RST : i_cfg_data[5:0];
                end
                wssw_pkg::CFG_RUN_MODE: begin
                    // The one unused code falls back to the off mode.
                    n_cfg.run_mode = (i_cfg_data[1:0] > wssw_pkg::MODE_STOPPED)
                        ? wssw_pkg::MODE_STOPPED : i_cfg_data[1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scheduler_enable <= 1'b0;
            r_cfg.day_mask         <= '0;
            r_cfg.sleep_hour       <= wssw_pkg::SLEEP_HOUR_RST;
            r_cfg.sleep_minute     <= wssw_pkg::SLEEP_MIN_RST;
            r_cfg.wake_hour        <= wssw_pkg::WAKE_HOUR_RST;
            r_cfg.wake_minute      <= wssw_pkg::WAKE_MIN_RST;
            r_cfg.run_mode         <= wssw_pkg::MODE_STOPPED;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/wssw_eval.sv
module wssw_eval (
    input  wssw_pkg::t_cfg    i_cfg,
    input  wssw_pkg::t_item   i_item,
    input  wssw_pkg::t_state  i_state,
    output wssw_pkg::t_state  o_state,
    output wssw_pkg::t_result o_result
);

    logic                         active;
    logic                         today;
    logic [7:0]                   day_bits;
    logic [wssw_pkg::KEY_W-1:0]   key;
    logic                         sleep_hit;
    logic                         wake_hit;
    logic                         sev;
    logic                         wev;
    logic                         sleeping_mid;
    logic [wssw_pkg::SECS_W-1:0]  now_s;
    logic [wssw_pkg::SECS_W-1:0]  sleep_s;
    logic [wssw_pkg::SECS_W-1:0]  wake_s;
    logic [wssw_pkg::SECS_W:0]    d_sleep;
    logic [wssw_pkg::SECS_W:0]    d_wake;
    logic                         sleep_soon;
    logic                         wake_soon;
    logic [wssw_pkg::MINS_W-1:0]  now_m;
    logic [wssw_pkg::MINS_W-1:0]  wake_m;
    logic [wssw_pkg::MINS_W-1:0]  sleep_m;
    logic                         in_window;

    assign active   = i_cfg.scheduler_enable && i_item.time_valid;
    // Weekday 7 selects the padding bit and so is never enabled.
    assign day_bits = {1'b0, i_cfg.day_mask};
    assign today    = day_bits[i_item.weekday];

    assign key = wssw_pkg::KEY_W'(i_item.year_day) * wssw_pkg::MIN_PER_DAY
               + wssw_pkg::KEY_W'(i_item.hour_now) * wssw_pkg::KEY_W'(wssw_pkg::MIN_PER_HOUR)
               + wssw_pkg::KEY_W'(i_item.minute_now);

    assign sleep_hit = active && today
                    && (i_item.hour_now == i_cfg.sleep_hour)
                    && (i_item.minute_now == i_cfg.sleep_minute)
                    && (i_state.last_sleep_key != key);
    assign wake_hit  = active
                    && (i_item.hour_now == i_cfg.wake_hour)
                    && (i_item.minute_now == i_cfg.wake_minute)
                    && (i_state.last_wake_key != key);

    // Sleep is resolved before wake, so both can fire on one tick.
    assign sev          = sleep_hit && !i_state.sleeping;
    assign sleeping_mid = i_state.sleeping || sleep_hit;
    assign wev          = wake_hit && sleeping_mid;

    assign o_state.sleeping       = sleeping_mid && !wake_hit;
    assign o_state.last_sleep_key = sleep_hit ? key : i_state.last_sleep_key;
    assign o_state.last_wake_key  = wake_hit ? key : i_state.last_wake_key;

    assign now_s   = wssw_pkg::SECS_W'(i_item.hour_now) * wssw_pkg::SEC_PER_HOUR
                   + wssw_pkg::SECS_W'(i_item.minute_now) * wssw_pkg::SEC_PER_MIN
                   + wssw_pkg::SECS_W'(i_item.second_now);
    assign sleep_s = wssw_pkg::SECS_W'(i_cfg.sleep_hour) * wssw_pkg::SEC_PER_HOUR
                   + wssw_pkg::SECS_W'(i_cfg.sleep_minute) * wssw_pkg::SEC_PER_MIN;
    assign wake_s  = wssw_pkg::SECS_W'(i_cfg.wake_hour) * wssw_pkg::SEC_PER_HOUR
                   + wssw_pkg::SECS_W'(i_cfg.wake_minute) * wssw_pkg::SEC_PER_MIN;

    assign d_sleep = {1'b0, sleep_s} - {1'b0, now_s};
    assign d_wake  = {1'b0, wake_s} - {1'b0, now_s};

    // A difference from one to five seconds has only its low three bits set.
    assign sleep_soon = (d_sleep[wssw_pkg::SECS_W:3] == '0) && (d_sleep[2:0] != 3'd0)
                     && (d_sleep[2:0] <= wssw_pkg::CD_MAX);
    assign wake_soon  = (d_wake[wssw_pkg::SECS_W:3] == '0) && (d_wake[2:0] != 3'd0)
                     && (d_wake[2:0] <= wssw_pkg::CD_MAX);

    assign now_m   = wssw_pkg::MINS_W'(i_item.hour_now) * wssw_pkg::MIN_PER_HOUR
                   + wssw_pkg::MINS_W'(i_item.minute_now);
    assign wake_m  = wssw_pkg::MINS_W'(i_cfg.wake_hour) * wssw_pkg::MIN_PER_HOUR
                   + wssw_pkg::MINS_W'(i_cfg.wake_minute);
    assign sleep_m = wssw_pkg::MINS_W'(i_cfg.sleep_hour) * wssw_pkg::MIN_PER_HOUR
                   + wssw_pkg::MINS_W'(i_cfg.sleep_minute);

    always_comb begin
        if (wake_m < sleep_m) begin
            in_window = (now_m >= wake_m) && (now_m < sleep_m);
        end else if (wake_m > sleep_m) begin
            // The window wraps past midnight.
            in_window = (now_m >= wake_m) || (now_m < sleep_m);
        end else begin
            in_window = 1'b0;
        end
    end

    always_comb begin
        o_result.sleep_event    = sev;
        o_result.wake_event     = wev;
        o_result.wake_mode      = wev ? i_cfg.run_mode : wssw_pkg::MODE_AUTO;
        o_result.sleeping_now   = o_state.sleeping;
        o_result.awake_window   = active && today && in_window;
        o_result.countdown_kind = wssw_pkg::CD_NONE;
        o_result.countdown_left = 3'd0;
        if (active && today && sleep_soon) begin
            o_result.countdown_kind = wssw_pkg::CD_SLEEP;
            o_result.countdown_left = d_sleep[2:0];
        end else if (active && wake_soon) begin
            o_result.countdown_kind = wssw_pkg::CD_WAKE;
            o_result.countdown_left = d_wake[2:0];
        end
    end

endmodule
